// ----- sv/swept_box_collision_time_macros.svh -----
// Assertion helpers used by the RTL
`ifndef SWEPT_BOX_COLLISION_TIME_MACROS_SVH
`define SWEPT_BOX_COLLISION_TIME_MACROS_SVH

// same-cycle implication, reset-qualified
`define SBCT_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, reset-qualified
`define SBCT_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- sv/sbct_pkg.sv -----
package sbct_pkg;

    localparam int CB = 16;
    localparam int TIME_W = 32;
    localparam logic [TIME_W-1:0] MAX_TIME_RST = 32'h0001_0000;
    localparam logic [TIME_W-1:0] TIME_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [CB-1:0] a_min_x;
        logic signed [CB-1:0] a_min_y;
        logic signed [CB-1:0] a_max_x;
        logic signed [CB-1:0] a_max_y;
        logic signed [CB-1:0] b_min_x;
        logic signed [CB-1:0] b_min_y;
        logic signed [CB-1:0] b_max_x;
        logic signed [CB-1:0] b_max_y;
        logic signed [CB-1:0] a_vel_x;
        logic signed [CB-1:0] a_vel_y;
        logic signed [CB-1:0] b_vel_x;
        logic signed [CB-1:0] b_vel_y;
    } box_t;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] first_time;
    } res_t;

    typedef struct packed {
        logic bad;      // separated and not closing
        logic ent_div;  // entry time comes from a divide
        logic ext_div;  // exit time comes from a divide
    } axis_ctl_t;

endpackage

// ----- sv/sbct_axis.sv -----
module sbct_axis
    import sbct_pkg::*;
(
    input  logic signed [CB-1:0] amin,
    input  logic signed [CB-1:0] amax,
    input  logic signed [CB-1:0] bmin,
    input  logic signed [CB-1:0] bmax,
    input  logic signed [CB-1:0] va,
    input  logic signed [CB-1:0] vb,
    output axis_ctl_t            ctl,
    output logic [CB-1:0]        ent_gap,
    output logic [CB-1:0]        ext_gap,
    output logic [CB-1:0]        spd
);

    logic signed [CB:0] rv;
    logic signed [CB:0] rv_abs;
    logic signed [CB:0] gap_b;
    logic signed [CB:0] gap_a;
    logic signed [CB:0] gap_xp;
    logic signed [CB:0] gap_xn;
    logic               pos;
    logic               neg;
    logic               b_sep;
    logic               a_sep;

    always_comb
    begin
        rv     = {va[CB-1], va} - {vb[CB-1], vb};
        pos    = !rv[CB] && (rv != '0);
        neg    = rv[CB];
        rv_abs = neg ? -rv : rv;
        spd    = rv_abs[CB-1:0];
        b_sep  = bmin > amax;
        a_sep  = amin > bmax;
        gap_b  = {bmin[CB-1], bmin} - {amax[CB-1], amax};
        gap_a  = {amin[CB-1], amin} - {bmax[CB-1], bmax};
        gap_xp = {bmax[CB-1], bmax} - {amin[CB-1], amin};
        gap_xn = {amax[CB-1], amax} - {bmin[CB-1], bmin};
        ent_gap = b_sep ? gap_b[CB-1:0] : gap_a[CB-1:0];
        ext_gap = pos ? gap_xp[CB-1:0] : gap_xn[CB-1:0];
        ctl.bad     = (b_sep && !pos) || (!b_sep && a_sep && !neg);
        ctl.ent_div = b_sep || a_sep;
        ctl.ext_div = (pos && (bmax > amin)) || (neg && (amax > bmin));
    end

endmodule

// ----- sv/sbct_div_step.sv -----
module sbct_div_step
    import sbct_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic [CB-1:0] rem_i,
    input  logic [DW-1:0] q_i,
    input  logic [CB-1:0] dvs,
    output logic [CB-1:0] rem_o,
    output logic [DW-1:0] q_o
);

    logic [CB:0]   trial;
    logic [CB+1:0] diff;
    logic          ge;

    always_comb
    begin
        trial = {rem_i, q_i[DW-1]};
        diff  = {1'b0, trial} - {2'b00, dvs};
        ge    = !diff[CB+1];
        rem_o = ge ? diff[CB-1:0] : trial[CB-1:0];
        q_o   = {q_i[DW-2:0], ge};
    end

endmodule

// ----- sv/sbct_resolve.sv -----
module sbct_resolve
    import sbct_pkg::*;
#(
    parameter int DW = 32
)
(
    input  logic [3:0][DW-1:0] quo,
    input  axis_ctl_t          ctl_x,
    input  axis_ctl_t          ctl_y,
    input  logic [TIME_W-1:0]  max_time,
    output res_t               res
);

    localparam int XW = (DW > TIME_W) ? DW : TIME_W;

    logic [XW-1:0] ex;
    logic [XW-1:0] xx;
    logic [XW-1:0] ey;
    logic [XW-1:0] xy;
    logic [XW-1:0] first;
    logic [XW-1:0] last;
    logic [XW-1:0] mt;

    always_comb
    begin
        mt    = XW'(max_time);
        ex    = ctl_x.ent_div ? XW'(quo[0]) : '0;
        xx    = ctl_x.ext_div ? XW'(quo[1]) : mt;
        ey    = ctl_y.ent_div ? XW'(quo[2]) : '0;
        xy    = ctl_y.ext_div ? XW'(quo[3]) : mt;
        first = (ex > ey) ? ex : ey;
        last  = (xx < xy) ? xx : xy;
        if (ctl_x.bad || ctl_y.bad)
        begin
            res.hit        = 1'b0;
            res.first_time = TIME_SAT;
        end
        else
        begin
            res.hit        = (last > first) && (first < mt);
            res.first_time = (first > XW'(TIME_SAT)) ? TIME_SAT : first[TIME_W-1:0];
        end
    end

endmodule

// ----- sv/swept_box_collision_time.sv -----
// Channel | Signals                     | Payload
// box     | box_valid / box_ready       | box_t: two boxes and their velocities
// res     | res_valid / res_ready       | res_t: hit, first_time (Q16.16)
// cfg     | cfg_wr_en / cfg_wr_data     | max_time, written on a clock edge while enabled
//
// One transaction per cycle sustained while res_ready stays high. The restoring divider
// resolves one quotient bit per stage.
// Four divides (entry and exit on both axes) run as parallel lanes.
// rst_n is asynchronous; it clears stage valids and loads max_time with 1.0.
// Stalls hold only the stages that are full; empty stages keep filling.
`include "swept_box_collision_time_macros.svh"

module swept_box_collision_time
    import sbct_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              box_valid,
    output logic              box_ready,
    input  box_t              box,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data
);

    localparam int DW = CB + TIME_FRAC_BITS;
    localparam int NS = DW + 2;

    typedef struct packed {
        logic [3:0][CB-1:0] rem;
        logic [3:0][DW-1:0] q;
        logic [CB-1:0]      spd_x;
        logic [CB-1:0]      spd_y;
        axis_ctl_t          ctl_x;
        axis_ctl_t          ctl_y;
    } stage_t;

    logic [TIME_W-1:0] max_time_reg;
    logic [NS-1:0]     vld_reg;
    logic [NS:0]       adv;
    stage_t            pipe_reg [0:DW];
    stage_t            pipe_next [0:DW];
    res_t              res_reg;
    res_t              res_next;

    axis_ctl_t     ctl_x;
    axis_ctl_t     ctl_y;
    logic [CB-1:0] ent_x;
    logic [CB-1:0] ext_x;
    logic [CB-1:0] spd_x;
    logic [CB-1:0] ent_y;
    logic [CB-1:0] ext_y;
    logic [CB-1:0] spd_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_time_reg <= MAX_TIME_RST;
        else if (cfg_wr_en)
            max_time_reg <= cfg_wr_data;
    end

    // stage handshake: a stage moves when empty or when its successor moves
    assign adv[NS] = res_ready;
    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_adv
            assign adv[s] = !vld_reg[s] || adv[s+1];
        end
    endgenerate

    assign box_ready = adv[0];
    assign res_valid = vld_reg[NS-1];
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= box_valid;
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    sbct_axis u_axis_x (
        .amin    (box.a_min_x),
        .amax    (box.a_max_x),
        .bmin    (box.b_min_x),
        .bmax    (box.b_max_x),
        .va      (box.a_vel_x),
        .vb      (box.b_vel_x),
        .ctl     (ctl_x),
        .ent_gap (ent_x),
        .ext_gap (ext_x),
        .spd     (spd_x)
    );

    sbct_axis u_axis_y (
        .amin    (box.a_min_y),
        .amax    (box.a_max_y),
        .bmin    (box.b_min_y),
        .bmax    (box.b_max_y),
        .va      (box.a_vel_y),
        .vb      (box.b_vel_y),
        .ctl     (ctl_y),
        .ent_gap (ent_y),
        .ext_gap (ext_y),
        .spd     (spd_y)
    );

    // lanes: 0 x entry, 1 x exit, 2 y entry, 3 y exit
    always_comb
    begin
        pipe_next[0].rem   = '0;
        pipe_next[0].q[0]  = {ent_x, {TIME_FRAC_BITS{1'b0}}};
        pipe_next[0].q[1]  = {ext_x, {TIME_FRAC_BITS{1'b0}}};
        pipe_next[0].q[2]  = {ent_y, {TIME_FRAC_BITS{1'b0}}};
        pipe_next[0].q[3]  = {ext_y, {TIME_FRAC_BITS{1'b0}}};
        pipe_next[0].spd_x = spd_x;
        pipe_next[0].spd_y = spd_y;
        pipe_next[0].ctl_x = ctl_x;
        pipe_next[0].ctl_y = ctl_y;
    end

    genvar k, l;
    generate
        for (k = 1; k <= DW; k++)
        begin : g_div
            for (l = 0; l < 4; l++)
            begin : g_lane
                sbct_div_step #(.DW(DW)) u_step (
                    .rem_i (pipe_reg[k-1].rem[l]),
                    .q_i   (pipe_reg[k-1].q[l]),
                    .dvs   ((l < 2) ? pipe_reg[k-1].spd_x : pipe_reg[k-1].spd_y),
                    .rem_o (pipe_next[k].rem[l]),
                    .q_o   (pipe_next[k].q[l])
                );
            end
            assign pipe_next[k].spd_x = pipe_reg[k-1].spd_x;
            assign pipe_next[k].spd_y = pipe_reg[k-1].spd_y;
            assign pipe_next[k].ctl_x = pipe_reg[k-1].ctl_x;
            assign pipe_next[k].ctl_y = pipe_reg[k-1].ctl_y;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DW; i++)
        begin
            if (adv[i])
                pipe_reg[i] <= pipe_next[i];
        end
        if (adv[NS-1])
            res_reg <= res_next;
    end

    sbct_resolve #(.DW(DW)) u_resolve (
        .quo      (pipe_reg[DW].q),
        .ctl_x    (pipe_reg[DW].ctl_x),
        .ctl_y    (pipe_reg[DW].ctl_y),
        .max_time (max_time_reg),
        .res      (res_next)
    );

    `SBCT_ASSERT_NXT(a_enter, clk, rst_n, box_valid && box_ready, vld_reg[0], "accepted transaction not captured")
    `SBCT_ASSERT_NXT(a_hold, clk, rst_n, vld_reg[DW] && !adv[DW], vld_reg[DW], "stalled divider stage dropped")
    `SBCT_ASSERT_IMP(a_hit_time, clk, rst_n, res_valid && res.hit, res.first_time != TIME_SAT, "hit with never time")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sbct_pkg::*;

    localparam int LATENCY = 40;

    logic              clk;
    logic              rst_n;
    logic              box_valid;
    logic              box_ready;
    box_t              box;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;

    logic [31:0] horizon;
    res_t        expected_res_q[$];
    int          mismatch_cnt;
    int          res_cnt;
    int          hit_cnt;
    int          box_idle_pct;
    int          res_idle_pct;
    int          res_hold_cycles;

    swept_box_collision_time u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] sweep_div(longint gap, longint speed);
        logic [63:0] g;
        g = gap;
        return (g << 16) / speed;
    endfunction

    function automatic bit axis_span(longint amin, longint amax, longint bmin,
                                     longint bmax, longint rv,
                                     output logic [63:0] t_in,
                                     output logic [63:0] t_out);
        t_in = '0;
        t_out = '0;
        if (bmin > amax)
        begin
            if (rv <= 0)
                return 0;
            t_in = sweep_div(bmin - amax, rv);
        end
        else if (amin > bmax)
        begin
            if (rv >= 0)
                return 0;
            t_in = sweep_div(amin - bmax, -rv);
        end
        t_out = 64'(horizon);
        if (rv > 0 && bmax > amin)
            t_out = sweep_div(bmax - amin, rv);
        else if (rv < 0 && amax > bmin)
            t_out = sweep_div(amax - bmin, -rv);
        return 1;
    endfunction

    function automatic res_t predict_contact(box_t b);
        res_t        r;
        logic [63:0] ex, xx, ey, xy, first, last;
        bit          okx, oky;
        longint      rvx, rvy;
        rvx = longint'(b.a_vel_x) - longint'(b.b_vel_x);
        rvy = longint'(b.a_vel_y) - longint'(b.b_vel_y);
        okx = axis_span(b.a_min_x, b.a_max_x, b.b_min_x, b.b_max_x, rvx, ex, xx);
        oky = axis_span(b.a_min_y, b.a_max_y, b.b_min_y, b.b_max_y, rvy, ey, xy);
        if (!okx || !oky)
        begin
            r.hit = 1'b0;
            r.first_time = TIME_SAT;
            return r;
        end
        first = (ex > ey) ? ex : ey;
        last = (xx < xy) ? xx : xy;
        r.hit = (last > first) && (first < {32'd0, horizon});
        r.first_time = (first > 64'hFFFF_FFFF) ? TIME_SAT : first[31:0];
        return r;
    endfunction

    task automatic send_box(box_t b);
        while ($urandom_range(99) < box_idle_pct)
        begin
            box_valid <= 1'b0;
            @(posedge clk);
        end
        box_valid <= 1'b1;
        box <= b;
        expected_res_q.push_back(predict_contact(b));
        @(posedge clk);
        while (!box_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        box_valid <= 1'b0;
        while (expected_res_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic set_horizon(logic [31:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        horizon = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic box_t rand_box();
        box_t b;
        logic signed [15:0] base, w;
        if ($urandom_range(3) == 0)
        begin
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b.a_vel_x = rand_coord();
            b.b_min_y = rand_coord();
        end
        else
        begin
            base = 16'($urandom_range(2000) - 1000);
            w = 16'($urandom_range(300));
            b.a_min_x = base;
            b.a_max_x = base + w;
            b.a_min_y = 16'(base + $urandom_range(200) - 100);
            b.a_max_y = 16'(b.a_min_y + $urandom_range(300));
            b.b_min_x = 16'(base + $urandom_range(2000) - 1000);
            b.b_max_x = 16'(b.b_min_x + $urandom_range(300));
            b.b_min_y = 16'(b.a_min_y + $urandom_range(2000) - 1000);
            b.b_max_y = 16'(b.b_min_y + $urandom_range(300));
            b.a_vel_x = 16'($urandom_range(600) - 300);
            b.a_vel_y = 16'($urandom_range(600) - 300);
            b.b_vel_x = 16'($urandom_range(600) - 300);
            b.b_vel_y = 16'($urandom_range(600) - 300);
            if ($urandom_range(9) == 0)
                b.a_vel_x = rand_coord();
        end
        return b;
    endfunction

    function automatic box_t mk_box(int ax0, int ay0, int ax1, int ay1, int bx0,
                                    int by0, int bx1, int by1, int avx, int avy,
                                    int bvx, int bvy);
        box_t b;
        b.a_min_x = 16'(ax0); b.a_min_y = 16'(ay0);
        b.a_max_x = 16'(ax1); b.a_max_y = 16'(ay1);
        b.b_min_x = 16'(bx0); b.b_min_y = 16'(by0);
        b.b_max_x = 16'(bx1); b.b_max_y = 16'(by1);
        b.a_vel_x = 16'(avx); b.a_vel_y = 16'(avy);
        b.b_vel_x = 16'(bvx); b.b_vel_y = 16'(bvy);
        return b;
    endfunction

    task automatic test_directed();
        send_box(mk_box(0, 0, 10, 10, 20, 0, 30, 10, 20, 0, 0, 0));
        send_box(mk_box(20, 0, 30, 10, 0, 0, 10, 10, -20, 0, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 20, 0, 30, 10, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 20, 0, 30, 10, -5, 0, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 0, 20, 10, 30, 0, 5, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 10, 10, 20, 20, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 5, 5, 15, 15, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 10, 10, 5, 5, 15, 15, 3, -3, 0, 0));
        send_box(mk_box(10, 10, 0, 0, 5, 5, 15, 15, 1, 1, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                        1, 1, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                        32767, 32767, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                        -32768, -32768, 32767, 32767));
        send_box(mk_box(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_box(mk_box(0, 0, 1, 1, 100, 0, 101, 1, 100, 0, 0, 0));
        send_box(mk_box(0, 0, 1, 1, 101, 0, 102, 1, 100, 0, 0, 0));
        send_box(mk_box(0, 0, 1, 1, 50, 60, 51, 61, 25, 30, 0, 0));
        send_box(mk_box(0, 0, 1, 1, 5, 5, 6, 6, 1, 2, 0, 0));
    endtask

    task automatic test_random(int n);
        repeat (n)
            send_box(rand_box());
    endtask

    task automatic test_backpressure();
        res_hold_cycles = 300;
        box_idle_pct = 0;
        test_random(120);
        box_idle_pct = 33;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (res_hold_cycles > 0)
        begin
            res_ready <= 1'b0;
            res_hold_cycles <= res_hold_cycles - 1;
        end
        else
            res_ready <= ($urandom_range(99) >= res_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            res_cnt++;
            if (res.hit)
                hit_cnt++;
            if (expected_res_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transaction: hit=%0b t=%h", res.hit, res.first_time);
            end
            else
            begin
                res_t e;
                e = expected_res_q.pop_front();
                if (e.hit !== res.hit || e.first_time !== res.first_time)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp hit=%0b t=%h, got hit=%0b t=%h",
                                 e.hit, e.first_time, res.hit, res.first_time);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        box_valid = 1'b0;
        box = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        horizon = MAX_TIME_RST;
        mismatch_cnt = 0;
        res_cnt = 0;
        hit_cnt = 0;
        box_idle_pct = 33;
        res_idle_pct = 33;
        res_hold_cycles = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_horizon(32'd0);
        test_directed();
        set_horizon(32'hFFFF_FFFF);
        test_directed();
        test_random(400);
        set_horizon(32'h0004_0000);
        test_random(400);
        box_idle_pct = 0;
        res_idle_pct = 0;
        test_random(300);
        box_idle_pct = 33;
        res_idle_pct = 33;
        test_backpressure();
        set_horizon(32'h0000_8000);
        test_random(300);
        set_horizon(MAX_TIME_RST);
        test_random(350);
        drain();

        $display("covered %0d transactions, %0d hits, horizons 0..max, backpressure",
                 res_cnt, hit_cnt);
        if (mismatch_cnt == 0 && expected_res_q.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches, %0d outstanding", mismatch_cnt, expected_res_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sbct_pkg.sv
sv/sbct_axis.sv
sv/sbct_div_step.sv
sv/sbct_resolve.sv
sv/swept_box_collision_time.sv
dv/tb_top.sv
